// File: design/bblur_pkg.sv
// shared types, constants and register codes of the rgb box blur
`timescale 1ns / 1ps
`default_nettype none

package bblur_pkg;

  localparam int CH_W       = 8;
  localparam int SUM_W      = 12;
  localparam int COORD_W    = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int QUEUE_DEPTH    = 4;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int MIN_DIM      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  // which results one input item causes
  typedef struct packed {
    logic box;         // pixel one up and one left
    logic avg;         // that pixel is interior and gets the average
    logic right_edge;  // last column pixel of the row above
    logic own;         // the pixel itself, on the last row
  } flag_t;

  typedef struct packed {
    sum_t                 sum;
    pix_t                 pass;
    pix_t                 up1;
    pix_t                 cur;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    flag_t                flags;
  } qent_t;

endpackage

`default_nettype wire

// File: design/bblur_if.sv
// handshake channels of the rgb box blur: pixels in, results out, register writes
`timescale 1ns / 1ps
`default_nettype none

interface bblur_pix_if;
  import bblur_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;
  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface bblur_res_if;
  import bblur_pkg::*;
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    out_red;
  logic [CH_W-1:0]    out_green;
  logic [CH_W-1:0]    out_blue;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic               last_of_item;
  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_col, output out_row, output last_of_item, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_col, input out_row, input last_of_item, output ready);
endinterface

interface bblur_cfg_if;
  import bblur_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

`default_nettype wire

// File: design/bblur_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bblur_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/bblur_front.sv
// front end: counters, line store, window and classification of each pixel
`timescale 1ns / 1ps
`default_nettype none

module bblur_front #(
  parameter int MAX_WIDTH  = bblur_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bblur_pkg::DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bblur_pix_if.sink         pix_i,
  bblur_cfg_if.sink         cfg_i,
  output logic              q_valid_o,
  output bblur_pkg::qent_t  q_entry_o,
  input  logic              q_ready_i
);
  import bblur_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WL    = CW + 1;
  localparam int HL    = RW + 1;
  localparam int DIM_A = (WL > HL) ? WL : HL;
  localparam int DIM_W = (DIM_A > CFG_DATA_W) ? DIM_A : CFG_DATA_W;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = v;
    if (v < DIM_W'(MIN_DIM)) begin
      res = DIM_W'(MIN_DIM);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  function automatic sum_t sum9(input pix_t p [9]);
    sum_t s;
    s = '0;
    for (int i = 0; i < 9; i++) begin
      s.red   = s.red   + SUM_W'(p[i].red);
      s.green = s.green + SUM_W'(p[i].green);
      s.blue  = s.blue  + SUM_W'(p[i].blue);
    end
    return s;
  endfunction

  localparam logic [WL-1:0] W_RST =
    WL'(clamp_dim(DIM_W'(RESET_WIDTH), DIM_W'(MAX_WIDTH)));
  localparam logic [HL-1:0] H_RST =
    HL'(clamp_dim(DIM_W'(RESET_HEIGHT), DIM_W'(MAX_HEIGHT)));

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [WL-1:0]  wlim_q, wlim_d;
  logic [HL-1:0]  hlim_q, hlim_d;
  logic           a_valid_q, a_valid_d;
  pix_t           a_px_q;
  logic [CW-1:0]  a_col_q;
  logic [RW-1:0]  a_row_q;
  flag_t          a_flags_q, flags_d;
  pix_t           win_q [6];
  pix_t           win_d [6];

  logic           accept;
  logic           commit;
  logic           has_res;
  logic           col_last;
  logic           row_last;
  logic           restart;
  logic [2*PIX_W-1:0] line_rdata;
  pix_t           up1;
  pix_t           up2;
  pix_t           in_px;
  pix_t           nine [9];

  assign in_px   = '{red: pix_i.in_red, green: pix_i.in_green, blue: pix_i.in_blue};
  assign up2     = pix_t'(line_rdata[2*PIX_W-1:PIX_W]);
  assign up1     = pix_t'(line_rdata[PIX_W-1:0]);

  assign has_res   = a_flags_q.box | a_flags_q.right_edge | a_flags_q.own;
  assign commit    = a_valid_q && (!has_res || q_ready_i);
  assign pix_i.ready = !a_valid_q || commit;
  assign accept    = pix_i.valid && pix_i.ready;
  assign cfg_i.ready = 1'b1;

  assign col_last = ({1'b0, col_q} == (wlim_q - WL'(1)));
  assign row_last = ({1'b0, row_q} == (hlim_q - HL'(1)));

  always_comb begin
    flags_d.box        = (row_q != '0) && (col_q != '0);
    flags_d.avg        = (row_q >= RW'(2)) && (col_q >= CW'(2));
    flags_d.right_edge = (row_q != '0) && col_last;
    flags_d.own        = row_last;
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    wlim_d    = wlim_q;
    hlim_d    = hlim_q;
    a_valid_d = a_valid_q;
    win_d     = win_q;
    restart   = 1'b0;

    if (commit) begin
      a_valid_d = 1'b0;
      win_d[3]  = win_q[0];
      win_d[4]  = win_q[1];
      win_d[5]  = win_q[2];
      win_d[0]  = up2;
      win_d[1]  = up1;
      win_d[2]  = a_px_q;
    end

    if (accept) begin
      a_valid_d = 1'b1;
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end

    if (cfg_i.valid) begin
      unique case (cfg_i.reg_idx)
        REG_IMAGE_WIDTH: begin
          wlim_d  = WL'(clamp_dim(DIM_W'(cfg_i.wdata), DIM_W'(MAX_WIDTH)));
          restart = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          hlim_d  = HL'(clamp_dim(DIM_W'(cfg_i.wdata), DIM_W'(MAX_HEIGHT)));
          restart = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end

    if (restart) begin
      col_d = '0;
      row_d = '0;
      for (int i = 0; i < 6; i++) begin
        win_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      wlim_q    <= W_RST;
      hlim_q    <= H_RST;
      a_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      wlim_q    <= wlim_d;
      hlim_q    <= hlim_d;
      a_valid_q <= a_valid_d;
      win_q     <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_px_q    <= in_px;
      a_col_q   <= col_q;
      a_row_q   <= row_q;
      a_flags_q <= flags_d;
    end
  end

  // older row in the upper half, newer row in the lower half
  bblur_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (commit),
    .waddr_i (a_col_q),
    .wdata_i ({up1, a_px_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  assign nine = '{win_q[3], win_q[4], win_q[5], win_q[0], win_q[1], win_q[2],
                  up2, up1, a_px_q};

  assign q_valid_o = a_valid_q && has_res;

  always_comb begin
    q_entry_o.sum   = sum9(nine);
    q_entry_o.pass  = win_q[1];
    q_entry_o.up1   = up1;
    q_entry_o.cur   = a_px_q;
    q_entry_o.col   = COORD_W'(a_col_q);
    q_entry_o.row   = COORD_W'(a_row_q);
    q_entry_o.flags = a_flags_q;
  end

endmodule

`default_nettype wire

// File: design/bblur_queue.sv
// short fifo of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module bblur_queue #(
  parameter int DEPTH = bblur_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  bblur_pkg::qent_t push_entry_i,
  output logic             push_ready_o,
  output logic             head_valid_o,
  output bblur_pkg::qent_t head_entry_o,
  input  logic             pop_i
);
  import bblur_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  qent_t           mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != NW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + NW'(1);
    end else if (pop && !push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// File: design/bblur_back.sv
// back end: divides the sums of interior pixels by nine and sends out the results of each item
`timescale 1ns / 1ps
`default_nettype none

module bblur_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  bblur_pkg::qent_t head_i,
  output logic             pop_o,
  bblur_res_if.source      res_o
);
  import bblur_pkg::*;

  // floor(s / 9) == (s * 3641) >> 15 for every sum of nine 8-bit values
  localparam logic [SUM_W-1:0] RECIP_NINE  = SUM_W'(3641);
  localparam int               RECIP_SHIFT = 15;

  localparam int SLOT_BOX   = 0;
  localparam int SLOT_RIGHT = 1;
  localparam int SLOT_OWN   = 2;

  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [2*SUM_W-1:0] prod;
    prod = (2*SUM_W)'(s) * (2*SUM_W)'(RECIP_NINE);
    return prod[RECIP_SHIFT +: CH_W];
  endfunction

  logic [2:0]          done_q, done_d;
  logic [2:0]          pend;
  logic [2:0]          sel;
  logic                last;
  logic                out_free;
  logic                load;
  pix_t                box_px;
  pix_t                res_px;
  logic [COORD_W-1:0]  res_col;
  logic [COORD_W-1:0]  res_row;

  logic                out_valid_q, out_valid_d;
  pix_t                out_px_q;
  logic [COORD_W-1:0]  out_col_q;
  logic [COORD_W-1:0]  out_row_q;
  logic                out_last_q;

  always_comb begin
    pend[SLOT_BOX]   = head_i.flags.box;
    pend[SLOT_RIGHT] = head_i.flags.right_edge;
    pend[SLOT_OWN]   = head_i.flags.own;
    pend             = pend & ~done_q;
  end

  assign sel      = pend & (~pend + 3'd1);
  assign last     = ((pend & ~sel) == 3'b000);
  assign out_free = !out_valid_q || res_o.ready;
  assign load     = head_valid_i && out_free;
  assign pop_o    = load && last;

  always_comb begin
    if (head_i.flags.avg) begin
      box_px.red   = div9(head_i.sum.red);
      box_px.green = div9(head_i.sum.green);
      box_px.blue  = div9(head_i.sum.blue);
    end else begin
      box_px = head_i.pass;
    end
  end

  always_comb begin
    if (sel[SLOT_BOX]) begin
      res_px  = box_px;
      res_col = head_i.col - COORD_W'(1);
      res_row = head_i.row - COORD_W'(1);
    end else if (sel[SLOT_RIGHT]) begin
      res_px  = head_i.up1;
      res_col = head_i.col;
      res_row = head_i.row - COORD_W'(1);
    end else begin
      res_px  = head_i.cur;
      res_col = head_i.col;
      res_row = head_i.row;
    end
  end

  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      done_d      = last ? 3'b000 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_px_q   <= res_px;
      out_col_q  <= res_col;
      out_row_q  <= res_row;
      out_last_q <= last;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_red      = out_px_q.red;
  assign res_o.out_green    = out_px_q.green;
  assign res_o.out_blue     = out_px_q.blue;
  assign res_o.out_col      = out_col_q;
  assign res_o.out_row      = out_row_q;
  assign res_o.last_of_item = out_last_q;

endmodule

`default_nettype wire

// File: design/box_blur_3x3_rgb.sv
// top level of the 3x3 rgb box blur
`timescale 1ns / 1ps
`default_nettype none

// Takes one rgb pixel per clock in raster order and returns each pixel of the
// frame, interior pixels as the floor of their 3x3 mean per channel and border
// pixels unchanged, one row and one column behind the input, with coordinates;
// the last row leaves as it arrives. Results leave one per clock through the
// output register while the receiver is ready, so the block takes one pixel per
// clock while each pixel causes at most one result; pixels that cause two or
// three results (the last column of rows below row 0, the last row but its
// first pixel) send them in turn via a four-entry queue. The line store has one
// read and one write port, each used once per pixel. With the queue empty and
// the output free, a pixel's first result passes the pixel register, the queue
// and the output register. A width or height write restarts the frame at row 0;
// widths and heights outside 3 to the maximum are clamped. Row 0 gives no result.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = bblur_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bblur_pkg::DEF_MAX_HEIGHT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bblur_pix_if.sink    pix_i,
  bblur_res_if.source  res_o,
  bblur_cfg_if.sink    cfg_i
);
  import bblur_pkg::*;

  logic  q_push_valid;
  logic  q_push_ready;
  qent_t q_push_entry;
  logic  head_valid;
  qent_t head_entry;
  logic  q_pop;

  bblur_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .cfg_i     (cfg_i),
    .q_valid_o (q_push_valid),
    .q_entry_o (q_push_entry),
    .q_ready_i (q_push_ready)
  );

  bblur_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_entry_i (q_push_entry),
    .push_ready_o (q_push_ready),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .pop_i        (q_pop)
  );

  bblur_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (q_pop),
    .res_o        (res_o)
  );

  // input stalls only when a classified item waits on a full queue
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (q_push_valid && !q_push_ready))
    else $error("input stalled without a blocked queue push");

  // a blocked push is kept until the queue takes it
  a_push_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_valid && !q_push_ready) |=> q_push_valid)
    else $error("queue push dropped while blocked");

  // the rest of an item follows right after a result that is not its last
  a_item_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !res_o.last_of_item) |=> res_o.valid)
    else $error("results of one item not contiguous");

  a_pop_with_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench of the rgb box blur: raster frames checked against a line-buffer predictor
`timescale 1ns / 1ps

module testbench;
  import bblur_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int RANDOM_ITEMS  = 260;
  localparam int PHASE_CAP     = 65;
  localparam int WIDE_WIDTH    = 64;
  localparam int WIDE_ITEMS    = 72;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    pix_t               px;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } blur_res_t;

  logic clk_i;
  logic rst_ni;

  bblur_pix_if pix_ch ();
  bblur_res_if res_ch ();
  bblur_cfg_if cfg_ch ();

  box_blur_3x3_rgb DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  pix_t      pixels_to_send [$];
  blur_res_t blurred_expected [$];

  // predictor state
  pix_t                  line_old [DEF_MAX_WIDTH];
  pix_t                  line_new [DEF_MAX_WIDTH];
  pix_t                  window [6];
  int unsigned           col_cnt = 0;
  int unsigned           row_cnt = 0;
  logic [CFG_DATA_W-1:0] cfg_width = CFG_DATA_W'(RESET_WIDTH);
  logic [CFG_DATA_W-1:0] cfg_height = CFG_DATA_W'(RESET_HEIGHT);

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_active = 1'b0;
  int   n_errors = 0;
  int   cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void predict_blur(pix_t px);
    int unsigned w, h, c, r, n;
    int unsigned sr, sg, sb;
    pix_t        up1, up2, val;
    pix_t        nb [9];
    blur_res_t   found [3];
    w = clamp_dim(cfg_width, DEF_MAX_WIDTH);
    h = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
    c = col_cnt;
    r = row_cnt;
    n = 0;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    up1 = line_new[c];
    up2 = line_old[c];
    if (r >= 1 && c >= 1) begin
      if (c >= 2 && r >= 2) begin
        nb = '{window[3], window[4], window[5], window[0], window[1], window[2], up2, up1, px};
        sr = 0;
        sg = 0;
        sb = 0;
        for (int i = 0; i < 9; i++) begin
          sr += nb[i].red;
          sg += nb[i].green;
          sb += nb[i].blue;
        end
        val.red   = CH_W'(sr / 9);
        val.green = CH_W'(sg / 9);
        val.blue  = CH_W'(sb / 9);
      end else begin
        val = window[1];
      end
      found[n] = '{val, COORD_W'(c - 1), COORD_W'(r - 1), 1'b0};
      n++;
    end
    if (r >= 1 && c == w - 1) begin
      found[n] = '{up1, COORD_W'(c), COORD_W'(r - 1), 1'b0};
      n++;
    end
    if (r == h - 1) begin
      found[n] = '{px, COORD_W'(c), COORD_W'(r), 1'b0};
      n++;
    end
    if (n > 0) found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) blurred_expected.push_back(found[i]);

    line_old[c] = up1;
    line_new[c] = px;
    window[3] = window[0];
    window[4] = window[1];
    window[5] = window[2];
    window[0] = up2;
    window[1] = up1;
    window[2] = px;

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // pixel driver
  always @(posedge clk_i) begin
    pix_t nxt;
    if (rst_ni && (!pix_ch.valid || pix_ch.ready)) begin
      if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pixels_to_send.pop_front();
        pix_ch.valid    <= 1'b1;
        pix_ch.in_red   <= nxt.red;
        pix_ch.in_green <= nxt.green;
        pix_ch.in_blue  <= nxt.blue;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk_i) begin
    if (rst_ni) res_ch.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
  end

  // monitor: predict on accepted pixels, check accepted results
  always @(posedge clk_i) begin
    blur_res_t want;
    if (rst_ni) begin
      if (pix_ch.valid && pix_ch.ready)
        predict_blur({pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue});
      if (res_ch.valid && res_ch.ready) begin
        if (blurred_expected.size() == 0) begin
          $error("unexpected result at col %0d row %0d", res_ch.out_col, res_ch.out_row);
          n_errors++;
        end else begin
          want = blurred_expected.pop_front();
          check_field("out_red", want.px.red, res_ch.out_red);
          check_field("out_green", want.px.green, res_ch.out_green);
          check_field("out_blue", want.px.blue, res_ch.out_blue);
          check_field("out_col", want.col, res_ch.out_col);
          check_field("out_row", want.row, res_ch.out_row);
          check_field("last_of_item", want.last, res_ch.last_of_item);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.reg_idx <= idx;
    cfg_ch.wdata   <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        cfg_width = data;
        col_cnt = 0;
        row_cnt = 0;
        window = '{default: '0};
      end
      REG_IMAGE_HEIGHT: begin
        cfg_height = data;
        col_cnt = 0;
        row_cnt = 0;
        window = '{default: '0};
      end
      default: ;
    endcase
  endtask

  // wait until every pixel is in and every result is out, then let the pipe settle
  task automatic drain();
    do @(negedge clk_i);
    while (pixels_to_send.size() != 0 || pix_ch.valid || blurred_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int                    phase, n, w, eff_h, flavor, sel, random_items;
    logic [CFG_DATA_W-1:0] wv, hv;
    pix_t                  p, base;

    rst_ni = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.in_red = '0;
    pix_ch.in_green = '0;
    pix_ch.in_blue = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_idx = REG_IMAGE_WIDTH;
    cfg_ch.wdata = '0;
    random_items = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // smallest frame via clamping, saturated interior
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    @(negedge clk_i);
    repeat (9) pixels_to_send.push_back(pix_t'(24'hFFFFFF));
    pixels_to_send.push_back(pix_t'(24'hAA55F0));
    pixels_to_send.push_back(pix_t'(24'h55AA0F));
    pixels_to_send.push_back(pix_t'(24'h00FF80));
    pixels_to_send.push_back(pix_t'(24'hFF007F));
    drain();

    // unused register index must not restart the frame
    write_reg(REG_SPARE_A, CFG_DATA_W'(12'hFFF));
    @(negedge clk_i);
    pixels_to_send.push_back(pix_t'(24'h000000));
    pixels_to_send.push_back(pix_t'(24'hFFFFFF));
    pixels_to_send.push_back(pix_t'(24'h000000));
    pixels_to_send.push_back(pix_t'(24'h0F0F0F));
    pixels_to_send.push_back(pix_t'(24'hF0F0F0));
    drain();

    // wide row, height clamped from all ones
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(WIDE_WIDTH));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(12'hFFF));
    @(negedge clk_i);
    repeat (WIDE_ITEMS) pixels_to_send.push_back(pix_t'(PIX_W'($urandom)));
    drain();

    phase = 0;
    while (random_items < RANDOM_ITEMS || phase < 4) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 0;  stall_pct = 59; end
        2: begin send_idle_pct = 59; stall_pct = 0;  end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase

      sel = $urandom_range(7);
      if (sel == 0) wv = CFG_DATA_W'($urandom_range(0, 2));
      else if (sel == 1) wv = CFG_DATA_W'($urandom_range(10, 24));
      else wv = CFG_DATA_W'($urandom_range(3, 9));
      sel = $urandom_range(7);
      if (sel == 0) hv = CFG_DATA_W'($urandom_range(0, 2));
      else if (sel == 1) hv = CFG_DATA_W'($urandom_range(2049, 4095));
      else hv = CFG_DATA_W'($urandom_range(3, 7));

      sel = $urandom_range(3);
      if (phase == 0 || sel != 2) write_reg(REG_IMAGE_WIDTH, wv);
      if (phase == 0 || sel != 1) write_reg(REG_IMAGE_HEIGHT, hv);
      if (sel == 3)
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));

      w = clamp_dim(cfg_width, DEF_MAX_WIDTH);
      eff_h = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
      if (eff_h > 7) eff_h = 7;
      n = $urandom_range(w, 2 * w * eff_h + w);
      if (n > PHASE_CAP) n = PHASE_CAP;

      if (phase == 1) begin
        if (n < 4 * w) n = 4 * w;
        fork
          begin
            @(posedge clk_i);
            hold_active <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk_i);
            hold_active <= 1'b0;
          end
        join_none
      end

      flavor = $urandom_range(3);
      base = pix_t'(PIX_W'($urandom));
      @(negedge clk_i);
      for (int k = 0; k < n; k++) begin
        case (flavor)
          0: p = pix_t'(PIX_W'($urandom));
          1: p = {CH_W'($urandom_range(224, 255)), CH_W'($urandom_range(224, 255)),
                  CH_W'($urandom_range(224, 255))};
          2: p = {CH_W'($urandom_range(0, 31)), CH_W'($urandom_range(0, 31)),
                  CH_W'($urandom_range(0, 31))};
          default: p = ($urandom_range(3) == 0) ? pix_t'(PIX_W'($urandom)) : base;
        endcase
        pixels_to_send.push_back(p);
      end
      random_items += n;
      drain();
      phase++;
    end

    if (n_errors == 0 && blurred_expected.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
